@@ design/pva_pkg.sv @@
package pva_pkg;

    // default sizes
    localparam int MAX_BANDS_DEF  = 2049;
    localparam int PHASE_BITS_DEF = 16;

    // fixed field widths
    localparam int AMP_W      = 16;
    localparam int BAND_W     = 12;
    localparam int SCALE_W    = 24;
    localparam int SCALE_FRAC = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd4096;
    localparam logic [BAND_W-1:0]  BANDS_RESET = 12'd2049;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_FACTOR = 1'b0,
        REG_BANDS_IN_USE = 1'b1
    } t_cfg_reg;

    // band slot of the item at the input
    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic              last;
    } t_band;

    // store clearing sweep after reset
    typedef struct packed {
        logic              active;
        logic [BAND_W-1:0] addr;
    } t_clr;

endpackage

@@ design/pva_if.sv @@
// band input channel
interface pva_in_if #(
    parameter int PHASE_BITS = pva_pkg::PHASE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [pva_pkg::AMP_W-1:0]     amplitude;
    logic signed [PHASE_BITS-1:0]  phase_in;

    modport source (output valid, output amplitude, output phase_in, input ready);
    modport sink   (input valid, input amplitude, input phase_in, output ready);
endinterface

// band result channel
interface pva_out_if #(
    parameter int PHASE_BITS = pva_pkg::PHASE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [pva_pkg::AMP_W-1:0]     amplitude_out;
    logic signed [PHASE_BITS-1:0]  phase_out;
    logic [pva_pkg::BAND_W-1:0]    band_index;
    logic                          frame_end;

    modport source (output valid, output amplitude_out, output phase_out,
                    output band_index, output frame_end, input ready);
    modport sink   (input valid, input amplitude_out, input phase_out,
                    input band_index, input frame_end, output ready);
endinterface

// register write channel
interface pva_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pva_pkg::CFG_IDX_W-1:0]     index;
    logic [pva_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/phase_vocoder_phase_advance.sv @@
// Pipeline: a band's result passes the store read, the scale multiply and the
// round/add into the output register before it is presented.
// Throughput: one band per cycle unless the result side stalls; each band reads and
// writes its stored phases through one two-port memory, forwarding between same-band items.
// Reset: synchronous, active low; a clearing sweep then zeroes all MAX_BANDS entries
// of the phase store (2049 by default), with input ready low; config writes still taken.
module phase_vocoder_phase_advance #(
    parameter int MAX_BANDS  = pva_pkg::MAX_BANDS_DEF,
    parameter int PHASE_BITS = pva_pkg::PHASE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pva_in_if.sink    i_in,
    pva_out_if.source o_out,
    pva_cfg_if.sink   i_cfg
);
    import pva_pkg::*;

    localparam int AW = $clog2(MAX_BANDS);

    logic [SCALE_W-1:0]      scale;
    t_band                   band;
    t_clr                    clr;
    logic                    in_ready;
    logic                    accept;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [2*PHASE_BITS-1:0] ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [2*PHASE_BITS-1:0] ram_rdata;
    logic [PHASE_BITS-1:0]   phase_out;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign accept      = i_in.valid && in_ready;

    // config registers, band counter, clearing sweep
    pva_ctrl #(
        .MAX_BANDS (MAX_BANDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_accept    (accept),
        .o_scale     (scale),
        .o_band      (band),
        .o_clr       (clr)
    );

    // read-modify-write datapath
    pva_pipe #(
        .MAX_BANDS  (MAX_BANDS),
        .PHASE_BITS (PHASE_BITS)
    ) u_pipe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in.valid),
        .o_ready         (in_ready),
        .i_amplitude     (i_in.amplitude),
        .i_phase_in      (i_in.phase_in),
        .i_band          (band),
        .i_scale         (scale),
        .i_clr           (clr),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_amplitude_out (o_out.amplitude_out),
        .o_phase_out     (phase_out),
        .o_band_index    (o_out.band_index),
        .o_frame_end     (o_out.frame_end),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_re        (ram_re),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata)
    );

    assign o_out.phase_out = phase_out;

    // phase store: {last output phase, last input phase} per band
    pva_ram #(
        .WIDTH (2 * PHASE_BITS),
        .DEPTH (MAX_BANDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // no band taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !clr.active)
        else $error("band accepted during store clearing");

    // no result can exist during the clearing sweep
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr.active |-> !o_out.valid)
        else $error("result presented during store clearing");

    // accepted band always addresses a real store entry
    a_band_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (band.band < BAND_W'(MAX_BANDS)))
        else $error("band slot beyond store depth");

    // after a frame's last band the counter restarts at band zero
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && band.last && !i_cfg.valid) |=> (band.band == '0))
        else $error("band counter did not restart after frame end");
endmodule

@@ design/pva_ram.sv @@
module pva_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2049
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port; read during write returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/pva_ctrl.sv @@
module pva_ctrl #(
    parameter int MAX_BANDS = pva_pkg::MAX_BANDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [pva_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pva_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    output logic [pva_pkg::SCALE_W-1:0]    o_scale,
    output pva_pkg::t_band                 o_band,
    output pva_pkg::t_clr                  o_clr
);
    import pva_pkg::*;

    localparam logic [BAND_W-1:0] MAX_CNT   = BAND_W'(MAX_BANDS);
    localparam logic [BAND_W-1:0] LAST_ADDR = BAND_W'(MAX_BANDS - 1);

    logic [SCALE_W-1:0] r_scale;
    logic [BAND_W-1:0]  r_bands;
    logic [BAND_W-1:0]  r_cnt;
    logic               r_clr_active;
    logic [BAND_W-1:0]  r_clr_addr;

    logic [BAND_W-1:0]  count;
    logic [BAND_W-1:0]  band;
    logic               last;
    logic [BAND_W-1:0]  n_cnt;

    // effective band count and slot of the next item
    always_comb begin
        if (r_bands > MAX_CNT) begin
            count = MAX_CNT;
        end else if (r_bands == '0) begin
            count = BAND_W'(1);
        end else begin
            count = r_bands;
        end
        band  = (r_cnt >= count) ? '0 : r_cnt;
        last  = (band == count - BAND_W'(1));
        n_cnt = last ? '0 : band + BAND_W'(1);
    end

    // config registers, band counter, clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= SCALE_RESET;
            r_bands      <= BANDS_RESET;
            r_cnt        <= '0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_SCALE_FACTOR: r_scale <= i_cfg_data[SCALE_W-1:0];
                    REG_BANDS_IN_USE: r_bands <= i_cfg_data[BAND_W-1:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_cnt <= n_cnt;
            end
            if (r_clr_active) begin
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_active <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + BAND_W'(1);
                end
            end
        end
    end

    assign o_scale       = r_scale;
    assign o_band.band   = band;
    assign o_band.last   = last;
    assign o_clr.active  = r_clr_active;
    assign o_clr.addr    = r_clr_addr;
endmodule

@@ design/pva_pipe.sv @@
module pva_pipe #(
    parameter int MAX_BANDS  = pva_pkg::MAX_BANDS_DEF,
    parameter int PHASE_BITS = pva_pkg::PHASE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item in
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [pva_pkg::AMP_W-1:0]        i_amplitude,
    input  logic [PHASE_BITS-1:0]            i_phase_in,
    input  pva_pkg::t_band                   i_band,
    input  logic [pva_pkg::SCALE_W-1:0]      i_scale,
    input  pva_pkg::t_clr                    i_clr,
    // result out
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pva_pkg::AMP_W-1:0]        o_amplitude_out,
    output logic [PHASE_BITS-1:0]            o_phase_out,
    output logic [pva_pkg::BAND_W-1:0]       o_band_index,
    output logic                             o_frame_end,
    // phase store
    output logic                             o_ram_we,
    output logic [$clog2(MAX_BANDS)-1:0]     o_ram_waddr,
    output logic [2*PHASE_BITS-1:0]          o_ram_wdata,
    output logic                             o_ram_re,
    output logic [$clog2(MAX_BANDS)-1:0]     o_ram_raddr,
    input  logic [2*PHASE_BITS-1:0]          i_ram_rdata
);
    import pva_pkg::*;

    localparam int AW = $clog2(MAX_BANDS);
    localparam int DW = PHASE_BITS + 1;
    localparam int PW = DW + SCALE_W + 1;
    localparam int RW = PHASE_BITS + SCALE_FRAC;
    localparam logic [RW-1:0] ROUND = RW'(1) << (SCALE_FRAC - 1);

    // stage 1: store read in flight
    logic                  r_v1;
    logic [AMP_W-1:0]      r1_amp;
    logic [PHASE_BITS-1:0] r1_phase;
    logic [BAND_W-1:0]     r1_band;
    logic                  r1_last;

    // stage 2: product ready
    logic                  r_v2;
    logic [AMP_W-1:0]      r2_amp;
    logic [PHASE_BITS-1:0] r2_phase;
    logic [BAND_W-1:0]     r2_band;
    logic                  r2_last;
    logic [PW-1:0]         r2_prod;
    logic [PHASE_BITS-1:0] r2_last_out;

    // output register
    logic                  r_ov;
    logic [AMP_W-1:0]      ro_amp;
    logic [PHASE_BITS-1:0] ro_phase;
    logic [BAND_W-1:0]     ro_band;
    logic                  ro_last;

    // most recent store write, for forwarding
    logic                  r_wb_valid;
    logic [BAND_W-1:0]     r_wb_band;
    logic [PHASE_BITS-1:0] r_wb_in;
    logic [PHASE_BITS-1:0] r_wb_out;

    logic                  accept;
    logic                  ro_free;
    logic                  s2_free;
    logic                  s2_move;
    logic                  s1_free;
    logic                  s2_write;

    logic [PHASE_BITS-1:0] s1_last_in;
    logic [PHASE_BITS-1:0] s1_last_out;
    logic signed [DW-1:0]  s1_diff;
    logic signed [PW-1:0]  s1_prod;

    logic [PHASE_BITS-1:0] s2_last_out;
    logic [RW-1:0]         s2_round;
    logic [PHASE_BITS-1:0] s2_new;
    logic [PHASE_BITS-1:0] s2_phase_out;

    // elastic pipeline flow
    assign ro_free  = !r_ov || i_ready;
    assign s2_move  = r_v2 && ro_free;
    assign s2_free  = !r_v2 || ro_free;
    assign s1_free  = !r_v1 || s2_free;
    assign o_ready  = s1_free && !i_clr.active;
    assign accept   = i_valid && o_ready;
    assign s2_write = s2_move && (r2_amp != '0);

    // stage 1: resolve stored phases, difference and scale
    always_comb begin
        s1_last_in  = i_ram_rdata[PHASE_BITS-1:0];
        s1_last_out = i_ram_rdata[2*PHASE_BITS-1:PHASE_BITS];
        if (r_wb_valid && (r_wb_band == r1_band)) begin
            s1_last_in  = r_wb_in;
            s1_last_out = r_wb_out;
        end
        // older item still in stage 2 has the newest input phase
        if (r_v2 && (r2_amp != '0) && (r2_band == r1_band)) begin
            s1_last_in = r2_phase;
        end
        s1_diff = $signed({r1_phase[PHASE_BITS-1], r1_phase})
                - $signed({s1_last_in[PHASE_BITS-1], s1_last_in});
        s1_prod = s1_diff * $signed({1'b0, i_scale});
    end

    // stage 2: round, add to last output phase, wrap
    always_comb begin
        s2_last_out = r2_last_out;
        if (r_wb_valid && (r_wb_band == r2_band)) begin
            s2_last_out = r_wb_out;
        end
        s2_round     = r2_prod[RW-1:0] + ROUND;
        s2_new       = s2_last_out + s2_round[RW-1:SCALE_FRAC];
        s2_phase_out = (r2_amp == '0) ? s2_last_out : s2_new;
    end

    // valid bits and forwarding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_ov       <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= accept;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (ro_free) begin
                r_ov <= r_v2;
            end
            if (s2_write) begin
                r_wb_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_amp   <= i_amplitude;
            r1_phase <= i_phase_in;
            r1_band  <= i_band.band;
            r1_last  <= i_band.last;
        end
        if (s2_free && r_v1) begin
            r2_amp      <= r1_amp;
            r2_phase    <= r1_phase;
            r2_band     <= r1_band;
            r2_last     <= r1_last;
            r2_prod     <= s1_prod;
            r2_last_out <= s1_last_out;
        end
        if (s2_move) begin
            ro_amp   <= r2_amp;
            ro_phase <= s2_phase_out;
            ro_band  <= r2_band;
            ro_last  <= r2_last;
        end
        if (s2_write) begin
            r_wb_band <= r2_band;
            r_wb_in   <= r2_phase;
            r_wb_out  <= s2_new;
        end
    end

    // store ports: clearing sweep or write-back
    always_comb begin
        if (i_clr.active) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = i_clr.addr[AW-1:0];
            o_ram_wdata = '0;
        end else begin
            o_ram_we    = s2_write;
            o_ram_waddr = r2_band[AW-1:0];
            o_ram_wdata = {s2_new, r2_phase};
        end
    end
    assign o_ram_re    = accept;
    assign o_ram_raddr = i_band.band[AW-1:0];

    assign o_valid         = r_ov;
    assign o_amplitude_out = ro_amp;
    assign o_phase_out     = ro_phase;
    assign o_band_index    = ro_band;
    assign o_frame_end     = ro_last;
endmodule

@@ test/pva_phase_check.sv @@
// watches the band, result and register channels, predicts each result and compares
module pva_phase_check #(
    parameter int MAX_BANDS = pva_pkg::MAX_BANDS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pva_in_if    i_in,
    pva_out_if   i_out,
    pva_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pva_pkg::*;

    localparam int PW = PHASE_BITS_DEF;

    typedef struct packed {
        logic [AMP_W-1:0]  amplitude;
        logic [PW-1:0]     phase;
        logic [BAND_W-1:0] band;
        logic              frame_end;
    } t_band_result;

    // shadow registers and per-band phase memories
    logic [SCALE_W-1:0] scale_q;
    logic [BAND_W-1:0]  band_count;
    logic [BAND_W-1:0]  next_band;
    logic [PW-1:0]      prev_in_phase  [MAX_BANDS];
    logic [PW-1:0]      prev_out_phase [MAX_BANDS];

    t_band_result synth_phase_q [$];
    int           fails = 0;

    // one band through the phase advance, updating the shadow stores
    function automatic t_band_result advance_band(input logic [AMP_W-1:0] amp,
                                                  input logic [PW-1:0]    ph);
        t_band_result       res;
        int unsigned        eff;
        int unsigned        b;
        logic signed [PW:0] diff;
        logic signed [47:0] prod;
        logic [PW-1:0]      step;
        eff = (band_count > MAX_BANDS) ? MAX_BANDS : band_count;
        if (eff == 0) eff = 1;
        // counter left past the end by a lowered count restarts the frame
        b = (next_band >= eff) ? 0 : next_band;
        res.amplitude = amp;
        res.band      = b[BAND_W-1:0];
        res.frame_end = (b == eff - 1);
        if (amp == '0) begin
            // silent band holds its phase and leaves the stores alone
            res.phase = prev_out_phase[b];
        end else begin
            diff = $signed({ph[PW-1], ph}) - $signed({prev_in_phase[b][PW-1], prev_in_phase[b]});
            prod = diff * $signed({24'd0, scale_q});
            // round half up, then wrap to one turn
            prod = prod + 48'sd2048;
            step = prod[SCALE_FRAC +: PW];
            res.phase = prev_out_phase[b] + step;
            prev_in_phase[b]  = ph;
            prev_out_phase[b] = res.phase;
        end
        next_band = res.frame_end ? '0 : BAND_W'(b + 1);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_band_result exp_res;
        if (!i_rst_n) begin
            scale_q    = SCALE_RESET;
            band_count = BANDS_RESET;
            next_band  = '0;
            for (int k = 0; k < MAX_BANDS; k++) begin
                prev_in_phase[k]  = '0;
                prev_out_phase[k] = '0;
            end
            synth_phase_q.delete();
        end else begin
            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_reg'(i_cfg.index))
                    REG_SCALE_FACTOR: scale_q = i_cfg.data[SCALE_W-1:0];
                    REG_BANDS_IN_USE: band_count = i_cfg.data[BAND_W-1:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest prediction
            if (i_out.valid && i_out.ready) begin
                if (synth_phase_q.size() == 0) begin
                    $error("result with no band pending: band_index %0d", i_out.band_index);
                    fails++;
                end else begin
                    exp_res = synth_phase_q.pop_front();
                    if (i_out.amplitude_out !== exp_res.amplitude) begin
                        $error("amplitude_out: expected %0d, got %0d",
                               exp_res.amplitude, i_out.amplitude_out);
                        fails++;
                    end
                    if (i_out.phase_out !== exp_res.phase) begin
                        $error("phase_out: expected %0d, got %0d (band %0d)",
                               $signed(exp_res.phase), $signed(i_out.phase_out), exp_res.band);
                        fails++;
                    end
                    if (i_out.band_index !== exp_res.band) begin
                        $error("band_index: expected %0d, got %0d",
                               exp_res.band, i_out.band_index);
                        fails++;
                    end
                    if (i_out.frame_end !== exp_res.frame_end) begin
                        $error("frame_end: expected %0d, got %0d (band %0d)",
                               exp_res.frame_end, i_out.frame_end, exp_res.band);
                        fails++;
                    end
                end
            end
            // band transaction
            if (i_in.valid && i_in.ready)
                synth_phase_q.push_back(advance_band(i_in.amplitude, i_in.phase_in));
        end
        o_pending    = synth_phase_q.size();
        o_fail_count = fails;
    end

endmodule

@@ test/tb_phase_vocoder_phase_advance.sv @@
module tb_phase_vocoder_phase_advance;
    timeunit 1ns;
    timeprecision 1ps;
    import pva_pkg::*;

    localparam int PW         = PHASE_BITS_DEF;
    localparam int RAND_BANDS = 420;
    localparam int HOLD_LEN   = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pva_in_if  in_ch ();
    pva_out_if out_ch ();
    pva_cfg_if cfg_ch ();

    int n_pending;
    int n_fails;
    int n_bands  = 0;
    int n_writes = 0;
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    bit hold_req  = 1'b0;

    phase_vocoder_phase_advance uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    pva_phase_check chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (n_fails),
        .o_pending    (n_pending)
    );

    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #1_000_000;
        $display("timeout with %0d results outstanding", n_pending);
        $display("phase_vocoder_phase_advance: mismatch");
        $finish;
    end

    // one band transaction, with an optional gap in front
    task automatic send_band(input logic [AMP_W-1:0] amp, input logic [PW-1:0] ph);
        int gap;
        gap = send_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) repeat (gap) @(negedge i_clk);
        in_ch.valid     = 1'b1;
        in_ch.amplitude = amp;
        in_ch.phase_in  = ph;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        n_bands++;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        n_writes++;
    endtask

    // band count write with junk in the unused data bits
    task automatic write_count(input logic [BAND_W-1:0] cnt);
        write_reg(REG_BANDS_IN_USE, {12'($urandom), cnt});
    endtask

    // wait until every band has come back, plus the pipeline depth
    task automatic settle();
        while (n_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [AMP_W-1:0] rand_amp();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3) return '0;
        if (r == 3) return '1;
        if (r == 4) return AMP_W'(1);
        return AMP_W'($urandom_range(1, 65535));
    endfunction

    function automatic logic [PW-1:0] rand_phase();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7fff;
        if (r == 2) return '0;
        return PW'($urandom);
    endfunction

    // result side: random stalls, and one long hold-off on request
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_req = 1'b0;
            end
            stall = recv_idle ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    // stimulus
    initial begin
        int  n_rand;
        int  items;
        int  r;
        bit  hold_done;
        in_ch.valid     = 1'b0;
        in_ch.amplitude = '0;
        in_ch.phase_in  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_SCALE_FACTOR;
        cfg_ch.data     = '0;
        i_rst_n         = 1'b0;
        n_rand          = 0;
        hold_done       = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes at reset settings, first bands of a long frame
        send_band(16'hffff, 16'h7fff);
        send_band(16'h0001, 16'h8000);
        send_band(16'h0000, 16'h1234);
        // count lowered below the band counter: next band starts a new frame
        settle();
        write_count(12'd3);
        send_band(16'h0001, 16'h8000);
        send_band(16'h0000, 16'h0000);
        send_band(16'h00ff, 16'h7fff);
        send_band(16'hff00, 16'h0064);
        // largest scale factor
        settle();
        write_reg(REG_SCALE_FACTOR, 24'hffffff);
        send_band(16'd300, 16'h0005);
        send_band(16'd7, 16'hfffb);
        send_band(16'hffff, 16'h7fff);
        // zero scale: output holds, input store still moves
        settle();
        write_reg(REG_SCALE_FACTOR, 24'd0);
        send_band(16'd2, 16'h03e8);
        send_band(16'd3, 16'hfc18);
        settle();
        write_reg(REG_SCALE_FACTOR, 24'd1);
        send_band(16'd4, 16'h8000);
        send_band(16'd5, 16'h7fff);
        // zero band count acts as a single band per frame
        settle();
        write_count(12'd0);
        send_band(16'd9, 16'h4000);
        send_band(16'd0, 16'h2000);
        send_band(16'd9, 16'hc000);
        // count above the maximum clamps, half scale hits round-half cases
        settle();
        write_count(12'hfff);
        write_reg(REG_SCALE_FACTOR, 24'd2048);
        send_band(16'd1, 16'h0003);
        send_band(16'd1, 16'hfffd);

        // random frames under changing settings
        while (n_rand < RAND_BANDS) begin
            settle();
            if ($urandom_range(0, 9) < 7) begin
                r = $urandom_range(0, 9);
                case (r)
                    0:       write_reg(REG_SCALE_FACTOR, 24'd0);
                    1:       write_reg(REG_SCALE_FACTOR, 24'hffffff);
                    2:       write_reg(REG_SCALE_FACTOR, SCALE_RESET);
                    3, 4:    write_reg(REG_SCALE_FACTOR, 24'($urandom));
                    default: write_reg(REG_SCALE_FACTOR, 24'($urandom_range(1, 16384)));
                endcase
            end
            if ($urandom_range(0, 9) < 7) begin
                r = $urandom_range(0, 9);
                case (r)
                    0:       write_count(12'd0);
                    1:       write_count(12'($urandom_range(1, 4)));
                    2:       write_count(12'($urandom_range(2049, 4095)));
                    default: write_count(12'($urandom_range(5, 40)));
                endcase
            end
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            items = $urandom_range(8, 60);
            // one phase where the result side backs off while bands keep coming
            if (!hold_done && n_rand >= 200) begin
                hold_done = 1'b1;
                send_idle = 1'b0;
                items     = 60;
                hold_req  = 1'b1;
            end
            for (int k = 0; k < items; k++) send_band(rand_amp(), rand_phase());
            n_rand += items;
        end

        settle();
        repeat (20) @(negedge i_clk);
        $display("bands sent: %0d over %0d register writes", n_bands, n_writes);
        $display("included zero and full scale, clamped and lowered counts, a long output stall");
        if (n_fails == 0) begin
            $display("phase_vocoder_phase_advance: match");
        end else begin
            $display("phase_vocoder_phase_advance: mismatch");
        end
        $finish;
    end

endmodule
